### design/mmcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mouse motion coalescing FIFO package
// Shared types, command codes and defaults for the coalescing report ring.
// ----------------------------------------------------------------------------
package mmcf_pkg;

   // Default number of ring slots; the ring holds one entry less than this.
   localparam int DEPTH_DEFAULT = 16;

   // Request command codes.
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   // One queued pointer report.
   typedef struct packed {
      logic [7:0]        buttons;
      logic signed [7:0] dx;
      logic signed [7:0] dy;
      logic signed [7:0] wheel;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push;       // Accepted push: merge or append, load result.
      logic pop_read;   // Accepted pop on a non-empty ring: read oldest slot.
      logic pop_empty;  // Accepted pop on an empty ring: load empty result.
      logic pop_load;   // Read data is ready: load it as the result.
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE     = 2'b01,
      ST_POP_WAIT = 2'b10
   } state_type;

endpackage : mmcf_pkg
`default_nettype wire

### design/mmcf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mouse motion coalescing FIFO controller
// Handshake control, pop sequencing and the result valid register.
// ----------------------------------------------------------------------------
module mmcf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_command,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire mmcf_pkg::status_type status,
   output mmcf_pkg::cmd_type         cmd
);

   mmcf_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                slot_busy;
   logic                load;

   // A new transaction is taken only in idle and when the result slot frees up.
   assign slot_busy = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != mmcf_pkg::ST_IDLE) || slot_busy;
   assign accept    = req_valid && !req_stall;

   // Commands to the datapath.
   always_comb begin
      cmd.push      = accept && (req_command == mmcf_pkg::CMD_PUSH);
      cmd.pop_read  = accept && (req_command == mmcf_pkg::CMD_POP) && !status.empty;
      cmd.pop_empty = accept && (req_command == mmcf_pkg::CMD_POP) && status.empty;
      cmd.pop_load  = (state_ff == mmcf_pkg::ST_POP_WAIT);
   end

   // Next state: a pop with data waits in ST_POP_WAIT for the memory read.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmcf_pkg::ST_IDLE: begin
            if (cmd.pop_read) begin
               state_in = mmcf_pkg::ST_POP_WAIT;
            end
         end
         mmcf_pkg::ST_POP_WAIT: begin
            state_in = mmcf_pkg::ST_IDLE;
         end
         default: begin
            state_in = mmcf_pkg::ST_IDLE;
         end
      endcase
   end

   // The result register fills on any load and empties when taken.
   assign load = cmd.push || cmd.pop_empty || cmd.pop_load;

   always_comb begin
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmcf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : mmcf_ctrl
`default_nettype wire

### design/mmcf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mouse motion coalescing FIFO datapath
// Ring memory, indices, newest-entry copy, merge arithmetic and result fields.
// ----------------------------------------------------------------------------
module mmcf_datapath #(
   parameter int DEPTH = mmcf_pkg::DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mmcf_pkg::cmd_type    cmd,
   output mmcf_pkg::status_type      status,
   input  wire logic [7:0]           req_in_buttons,
   input  wire logic signed [7:0]    req_in_dx,
   input  wire logic signed [7:0]    req_in_dy,
   input  wire logic signed [7:0]    req_in_wheel,
   output logic                      rsp_data_valid,
   output logic [7:0]                rsp_out_buttons,
   output logic signed [7:0]         rsp_out_dx,
   output logic signed [7:0]         rsp_out_dy,
   output logic signed [7:0]         rsp_out_wheel,
   output logic                      rsp_merged,
   output logic                      rsp_dropped_oldest
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

   // Ring slot index with wraparound at DEPTH.
   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == LAST_SLOT) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

   mmcf_pkg::entry_type mem [DEPTH];
   mmcf_pkg::entry_type rd_data_ff;
   mmcf_pkg::entry_type newest_ff, newest_in;
   mmcf_pkg::entry_type in_entry, sum_entry;
   logic [IDX_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]    wr_next, last_idx, mem_waddr;
   logic                empty, full, do_merge, fits;
   logic [8:0]          sum_dx, sum_dy, sum_wheel;

   logic                data_valid_ff;
   mmcf_pkg::entry_type out_ff;
   logic                merged_ff, dropped_ff;

   assign empty        = (rd_idx_ff == wr_idx_ff);
   assign status.empty = empty;
   assign wr_next      = wrap_next(wr_idx_ff);
   assign full         = (wr_next == rd_idx_ff);
   assign last_idx     = (wr_idx_ff == '0) ? LAST_SLOT : wr_idx_ff - 1'b1;

   assign in_entry = '{buttons: req_in_buttons, dx: req_in_dx, dy: req_in_dy,
                       wheel: req_in_wheel};

   // Nine-bit sums against the newest entry; a sum fits when its top two bits agree.
   assign sum_dx    = {newest_ff.dx[7], newest_ff.dx} + {req_in_dx[7], req_in_dx};
   assign sum_dy    = {newest_ff.dy[7], newest_ff.dy} + {req_in_dy[7], req_in_dy};
   assign sum_wheel = {newest_ff.wheel[7], newest_ff.wheel}
                      + {req_in_wheel[7], req_in_wheel};
   assign fits = (sum_dx[8] == sum_dx[7]) && (sum_dy[8] == sum_dy[7])
                 && (sum_wheel[8] == sum_wheel[7]);
   assign do_merge = !empty && (newest_ff.buttons == req_in_buttons) && fits;

   assign sum_entry = '{buttons: req_in_buttons, dx: sum_dx[7:0], dy: sum_dy[7:0],
                        wheel: sum_wheel[7:0]};

   // Index and newest-entry updates.
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      newest_in = newest_ff;
      mem_waddr = wr_idx_ff;
      if (cmd.push) begin
         if (do_merge) begin
            newest_in = sum_entry;
            mem_waddr = last_idx;
         end else begin
            newest_in = in_entry;
            wr_idx_in = wr_next;
            if (full) begin
               rd_idx_in = wrap_next(rd_idx_ff);
            end
         end
      end else if (cmd.pop_read) begin
         rd_idx_in = wrap_next(rd_idx_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff <= newest_in;
   end

   // Ring memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[mem_waddr] <= newest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop_read) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         data_valid_ff <= 1'b0;
         out_ff        <= '0;
         merged_ff     <= do_merge;
         dropped_ff    <= !do_merge && full;
      end else if (cmd.pop_empty) begin
         data_valid_ff <= 1'b0;
         out_ff        <= '0;
         merged_ff     <= 1'b0;
         dropped_ff    <= 1'b0;
      end else if (cmd.pop_load) begin
         data_valid_ff <= 1'b1;
         out_ff        <= rd_data_ff;
         merged_ff     <= 1'b0;
         dropped_ff    <= 1'b0;
      end
   end

   assign rsp_data_valid     = data_valid_ff;
   assign rsp_out_buttons    = out_ff.buttons;
   assign rsp_out_dx         = out_ff.dx;
   assign rsp_out_dy         = out_ff.dy;
   assign rsp_out_wheel      = out_ff.wheel;
   assign rsp_merged         = merged_ff;
   assign rsp_dropped_oldest = dropped_ff;

endmodule : mmcf_datapath
`default_nettype wire

### design/mouse_motion_coalescing_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mouse motion coalescing FIFO
// Ring queue of pointer reports that sums same-button pushes into the newest entry.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_*) carries one command per transaction: a push of a
// report (buttons, dx, dy, wheel) or a pop of the oldest queued report. Every
// request yields exactly one transaction on the response channel (rsp_*).
// A push is merged into the newest entry when the buttons match and all three
// sums stay in -128..127; otherwise it is appended, and a full ring drops its
// oldest entry first. The ring holds DEPTH-1 entries.
// Timing: a push or a pop of an empty ring has its response registered in the
// cycle after acceptance, so pushes sustain one transaction per cycle while the
// receiver does not stall. A pop that returns data reads the ring memory through
// its registered read port, waits in ST_POP_WAIT and then loads the result; no
// new request is taken until that load.
// Reset empties the ring (both indices zero) and clears the response valid.
// While the receiver stalls a held response, req_stall is raised and no new
// request is taken; the response payload holds steady.
// ----------------------------------------------------------------------------
module mouse_motion_coalescing_fifo #(
   parameter int DEPTH = mmcf_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_command,
   input  wire logic [7:0]        req_in_buttons,
   input  wire logic signed [7:0] req_in_dx,
   input  wire logic signed [7:0] req_in_dy,
   input  wire logic signed [7:0] req_in_wheel,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_data_valid,
   output logic [7:0]             rsp_out_buttons,
   output logic signed [7:0]      rsp_out_dx,
   output logic signed [7:0]      rsp_out_dy,
   output logic signed [7:0]      rsp_out_wheel,
   output logic                   rsp_merged,
   output logic                   rsp_dropped_oldest
);

   mmcf_pkg::cmd_type    cmd;
   mmcf_pkg::status_type status;

   // Controller: handshake and pop sequencing.
   mmcf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // Datapath: ring memory, indices and merge logic.
   mmcf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_in_buttons     (req_in_buttons),
      .req_in_dx          (req_in_dx),
      .req_in_dy          (req_in_dy),
      .req_in_wheel       (req_in_wheel),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_out_buttons    (rsp_out_buttons),
      .rsp_out_dx         (rsp_out_dx),
      .rsp_out_dy         (rsp_out_dy),
      .rsp_out_wheel      (rsp_out_wheel),
      .rsp_merged         (rsp_merged),
      .rsp_dropped_oldest (rsp_dropped_oldest)
   );

`ifndef SYNTH
   // A memory read for a pop is always followed by loading its data.
   a_pop_read_then_load: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_read |=> cmd.pop_load)
      else $error("pop read was not followed by a result load");

   // No new transaction is accepted while the pop data is being loaded.
   a_no_accept_in_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_load |-> !(req_valid && !req_stall))
      else $error("request accepted during pop wait");

   // A response never reports both a merge and a drop.
   a_merge_drop_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_merged && rsp_dropped_oldest))
      else $error("merged and dropped_oldest both set");

   // A response with popped data carries no push flags.
   a_pop_no_push_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_valid) |-> (!rsp_merged && !rsp_dropped_oldest))
      else $error("pop response carries push flags");
`endif

endmodule : mouse_motion_coalescing_fifo
`default_nettype wire

### bench/mouse_motion_coalescing_fifo_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mouse motion coalescing FIFO checker
// Watches the request and response channels and keeps its own copy of the
// report ring. It predicts the response of every accepted request and compares
// each accepted response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mouse_motion_coalescing_fifo_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic              req_command,
   input  wire logic [7:0]        req_in_buttons,
   input  wire logic signed [7:0] req_in_dx,
   input  wire logic signed [7:0] req_in_dy,
   input  wire logic signed [7:0] req_in_wheel,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              rsp_data_valid,
   input  wire logic [7:0]        rsp_out_buttons,
   input  wire logic signed [7:0] rsp_out_dx,
   input  wire logic signed [7:0] rsp_out_dy,
   input  wire logic signed [7:0] rsp_out_wheel,
   input  wire logic              rsp_merged,
   input  wire logic              rsp_dropped_oldest,
   output int                     error_count,
   output int                     pending_count
);

   localparam int SLOTS = mmcf_pkg::DEPTH_DEFAULT;

   // One predicted response transaction.
   typedef struct packed {
      logic                data_valid;
      mmcf_pkg::entry_type report;
      logic                merged;
      logic                dropped_oldest;
   } ring_result_type;

   // Shadow copy of the ring and its indices.
   mmcf_pkg::entry_type shadow_ring [SLOTS];
   int                  oldest_slot;
   int                  append_slot;
   ring_result_type     awaited_results [$];

   function automatic bit fits_in_byte(int value);
      return value >= -128 && value <= 127;
   endfunction

   // Applies one request to the shadow ring and returns the response it causes.
   function automatic ring_result_type predict_ring_result(logic command,
                                                            mmcf_pkg::entry_type report);
      ring_result_type     result;
      mmcf_pkg::entry_type newest;
      int                  newest_slot;
      int                  sum_dx;
      int                  sum_dy;
      int                  sum_wheel;
      result = '0;

      // A pop returns the oldest entry, or an all-zero response when empty.
      if (command == mmcf_pkg::CMD_POP) begin
         if (oldest_slot != append_slot) begin
            result.data_valid = 1'b1;
            result.report     = shadow_ring[oldest_slot];
            oldest_slot       = (oldest_slot + 1) % SLOTS;
         end
         return result;
      end

      // A push with matching buttons folds into the newest entry if no sum overflows.
      if (oldest_slot != append_slot) begin
         newest_slot = (append_slot + SLOTS - 1) % SLOTS;
         newest      = shadow_ring[newest_slot];
         if (newest.buttons == report.buttons) begin
            sum_dx    = int'(newest.dx) + int'(report.dx);
            sum_dy    = int'(newest.dy) + int'(report.dy);
            sum_wheel = int'(newest.wheel) + int'(report.wheel);
            if (fits_in_byte(sum_dx) && fits_in_byte(sum_dy) && fits_in_byte(sum_wheel)) begin
               shadow_ring[newest_slot] = {report.buttons, 8'(sum_dx), 8'(sum_dy),
                                           8'(sum_wheel)};
               result.merged = 1'b1;
               return result;
            end
         end
      end

      // Otherwise append, giving up the oldest entry when the ring is full.
      if ((append_slot + 1) % SLOTS == oldest_slot) begin
         oldest_slot           = (oldest_slot + 1) % SLOTS;
         result.dropped_oldest = 1'b1;
      end
      shadow_ring[append_slot] = report;
      append_slot              = (append_slot + 1) % SLOTS;
      return result;
   endfunction

   function automatic void compare_field(string field_name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 8'h%02h, actual 8'h%02h", field_name, want, got);
         error_count++;
      end
   endfunction

   // Both channels are sampled at the rising edge.
   always @(posedge clock) begin
      ring_result_type     want;
      mmcf_pkg::entry_type pushed;
      if (reset) begin
         oldest_slot = 0;
         append_slot = 0;
         awaited_results.delete();
      end else begin
         // Check a completed response transaction against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               compare_field("data_valid", 8'(want.data_valid), 8'(rsp_data_valid));
               compare_field("out_buttons", want.report.buttons, rsp_out_buttons);
               compare_field("out_dx", want.report.dx, rsp_out_dx);
               compare_field("out_dy", want.report.dy, rsp_out_dy);
               compare_field("out_wheel", want.report.wheel, rsp_out_wheel);
               compare_field("merged", 8'(want.merged), 8'(rsp_merged));
               compare_field("dropped_oldest", 8'(want.dropped_oldest),
                             8'(rsp_dropped_oldest));
            end
         end
         // Predict the response of an accepted request transaction.
         if (req_valid && !req_stall) begin
            pushed = {req_in_buttons, req_in_dx, req_in_dy, req_in_wheel};
            awaited_results.push_back(predict_ring_result(req_command, pushed));
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

### bench/tb_mouse_motion_coalescing_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mouse motion coalescing FIFO testbench
// Drives directed and random push and pop requests with varying idle and stall
// patterns, including a long response hold-off, and reports the verdict of
// the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_mouse_motion_coalescing_fifo;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_ITEMS  = 200;

   logic              clock;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic              req_command    = mmcf_pkg::CMD_PUSH;
   logic [7:0]        req_in_buttons = 8'h00;
   logic signed [7:0] req_in_dx      = 8'sd0;
   logic signed [7:0] req_in_dy      = 8'sd0;
   logic signed [7:0] req_in_wheel   = 8'sd0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic              rsp_data_valid;
   logic [7:0]        rsp_out_buttons;
   logic signed [7:0] rsp_out_dx;
   logic signed [7:0] rsp_out_dy;
   logic signed [7:0] rsp_out_wheel;
   logic              rsp_merged;
   logic              rsp_dropped_oldest;
   int                error_count;
   int                pending_count;

   // Idle and stall rates of the current phase, in percent.
   int                idle_pct   = 0;
   int                stall_pct  = 0;
   bit                hold_go    = 1'b0;
   int                hold_left  = 0;
   logic [7:0]        last_buttons = 8'h00;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   mouse_motion_coalescing_fifo dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_in_buttons     (req_in_buttons),
      .req_in_dx          (req_in_dx),
      .req_in_dy          (req_in_dy),
      .req_in_wheel       (req_in_wheel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_out_buttons    (rsp_out_buttons),
      .rsp_out_dx         (rsp_out_dx),
      .rsp_out_dy         (rsp_out_dy),
      .rsp_out_wheel      (rsp_out_wheel),
      .rsp_merged         (rsp_merged),
      .rsp_dropped_oldest (rsp_dropped_oldest)
   );

   mouse_motion_coalescing_fifo_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_in_buttons     (req_in_buttons),
      .req_in_dx          (req_in_dx),
      .req_in_dy          (req_in_dy),
      .req_in_wheel       (req_in_wheel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_out_buttons    (rsp_out_buttons),
      .rsp_out_dx         (rsp_out_dx),
      .rsp_out_dy         (rsp_out_dy),
      .rsp_out_wheel      (rsp_out_wheel),
      .rsp_merged         (rsp_merged),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   // The receiver stalls at random, or holds off for a long stretch on request.
   always @(negedge clock) begin
      if (hold_go) begin
         hold_go   = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offers one request transaction and returns at the falling edge after it is taken.
   task automatic issue_request(logic command, logic [7:0] buttons, logic signed [7:0] dx,
                                logic signed [7:0] dy, logic signed [7:0] wheel);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= command;
      req_in_buttons <= buttons;
      req_in_dx      <= dx;
      req_in_dy      <= dy;
      req_in_wheel   <= wheel;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic push_report(logic [7:0] buttons, logic signed [7:0] dx,
                              logic signed [7:0] dy, logic signed [7:0] wheel);
      issue_request(mmcf_pkg::CMD_PUSH, buttons, dx, dy, wheel);
   endtask

   // Pop fields carry noise, since the block ignores them.
   task automatic pop_report();
      issue_request(mmcf_pkg::CMD_POP, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
   endtask

   function automatic logic signed [7:0] random_delta();
      if ($urandom_range(1) == 0)
         return 8'(int'($urandom_range(16)) - 8);
      return 8'($urandom);
   endfunction

   // Mostly repeats the last buttons so that merges and their overflows are frequent.
   task automatic random_request(int push_pct);
      int         pick;
      logic [7:0] buttons;
      if ($urandom_range(99) < push_pct) begin
         pick = $urandom_range(9);
         if (pick < 6)
            buttons = last_buttons;
         else if (pick == 6)
            buttons = 8'h00;
         else if (pick == 7)
            buttons = 8'hFF;
         else
            buttons = 8'($urandom);
         last_buttons = buttons;
         push_report(buttons, random_delta(), random_delta(), random_delta());
      end else begin
         pop_report();
      end
   endtask

   // Stimulus and verdict.
   initial begin
      int phase;
      int item;
      int slot;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty pop, merges, overflowing merges, extremes, a full ring.
      pop_report();
      push_report(8'h00, 8'sd127, -8'sd128, 8'sd0);
      push_report(8'h00, 8'sd0, 8'sd0, 8'sd0);
      push_report(8'h00, 8'sd1, 8'sd0, 8'sd0);
      push_report(8'hFF, -8'sd128, -8'sd128, -8'sd128);
      push_report(8'hFF, -8'sd1, 8'sd0, 8'sd0);
      push_report(8'h5A, 8'sd3, -8'sd3, 8'sd127);
      push_report(8'h5A, -8'sd3, 8'sd3, -8'sd128);
      repeat (3) pop_report();
      for (slot = 0; slot < 14; slot++)
         push_report(8'(8'h10 + slot), 8'($urandom), 8'($urandom), 8'($urandom));
      push_report(8'h1D, 8'sd0, 8'sd0, 8'sd0);

      // Random phases: no idling, sender idle, receiver stalling, both lightly.
      for (phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               hold_go   = 1'b1;
            end
            1: begin
               idle_pct  = 74;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 74;
            end
            default: begin
               idle_pct  = 7;
               stall_pct = 7;
            end
         endcase
         // Alternate filling and draining stretches so the ring goes full and empty.
         for (item = 0; item < PHASE_ITEMS; item++)
            random_request(((item / 50) % 2 == 0) ? 75 : 30);
      end

      // Drain every outstanding response, then allow the pipeline to settle.
      req_valid <= 1'b0;
      stall_pct = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (error_count == 0)
         $display("mouse_motion_coalescing_fifo regression: pass");
      else
         $display("mouse_motion_coalescing_fifo regression: fail");
      $finish;
   end

   // Ends a hung run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("mouse_motion_coalescing_fifo regression: fail");
      $finish;
   end

endmodule

### sim.f
design/mmcf_pkg.sv
design/mmcf_ctrl.sv
design/mmcf_datapath.sv
design/mouse_motion_coalescing_fifo.sv
bench/mouse_motion_coalescing_fifo_checker.sv
bench/tb_mouse_motion_coalescing_fifo.sv
